// ----- rtl/trm_pkg.sv -----
// Shared types and constants for the tiny register machine execute block.
package trm_pkg;

  localparam int TRM_REG_COUNT   = 32;
  localparam int TRM_DATA_WORDS  = 512;
  localparam int TRM_QUEUE_DEPTH = 2;

  localparam int TRM_WORD_W  = 32;
  localparam int TRM_INSTR_W = 16;
  localparam int TRM_SRC_W   = 4;
  localparam int TRM_DST_W   = 5;
  localparam int TRM_ADDR_W  = 9;

  // instruction field positions
  localparam int TRM_OPC_LSB  = 13;
  localparam int TRM_SRCA_LSB = 9;
  localparam int TRM_SRCB_LSB = 5;

  typedef enum logic [2:0] {
    OPC_ADD   = 3'd0,
    OPC_MUL   = 3'd1,
    OPC_OR    = 3'd2,
    OPC_AND   = 3'd3,
    OPC_LOAD  = 3'd4,
    OPC_STORE = 3'd5
  } trm_opcode_t;

  typedef enum logic [2:0] {
    K_ADD,
    K_MUL,
    K_OR,
    K_AND,
    K_LOAD,
    K_STORE,
    K_HOST,
    K_NOP
  } trm_kind_t;

  typedef struct packed {
    trm_kind_t               kind;
    logic [TRM_SRC_W-1:0]    src_a;
    logic [TRM_SRC_W-1:0]    src_b;
    logic [TRM_DST_W-1:0]    dst;
    logic                    dst_ok;
    logic [TRM_ADDR_W-1:0]   addr;
    logic                    addr_ok;
    logic [TRM_WORD_W-1:0]   value;
  } trm_item_t;

endpackage

// ----- rtl/trm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module trm_ram
  import trm_pkg::*;
#(
  parameter int WIDTH = TRM_WORD_W,
  parameter int DEPTH = TRM_REG_COUNT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/trm_front.sv -----
// Front end: accepts input requests, decodes and range-checks them.
module trm_front
  import trm_pkg::*;
#(
  parameter int REG_COUNT  = TRM_REG_COUNT,
  parameter int DATA_WORDS = TRM_DATA_WORDS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [TRM_INSTR_W-1:0] in_instruction,
  input  logic [TRM_ADDR_W-1:0]  in_host_address,
  input  logic [TRM_WORD_W-1:0]  in_host_value,
  input  logic                   init_busy,
  input  logic                   q_ready,
  output logic                   q_push,
  output trm_item_t              q_item
);

  localparam logic [TRM_DST_W:0]  REG_LIMIT = (TRM_DST_W + 1)'(REG_COUNT);
  localparam logic [TRM_ADDR_W:0] MEM_LIMIT = (TRM_ADDR_W + 1)'(DATA_WORDS);

  trm_item_t   item_r, item_nxt;
  logic        vld_r, vld_nxt;
  trm_item_t   dec;
  trm_opcode_t opc;
  logic        in_fire;

  always_comb begin
    dec   = '0;
    dec.kind = K_NOP;
    opc   = trm_opcode_t'(in_instruction[TRM_OPC_LSB +: 3]);
    if (in_func) begin
      dec.kind  = K_HOST;
      dec.addr  = in_host_address;
      dec.value = in_host_value;
    end else begin
      dec.src_a = in_instruction[TRM_SRCA_LSB +: TRM_SRC_W];
      dec.src_b = in_instruction[TRM_SRCB_LSB +: TRM_SRC_W];
      dec.dst   = in_instruction[TRM_DST_W-1:0];
      dec.addr  = in_instruction[TRM_ADDR_W-1:0];
      unique case (opc)
        OPC_ADD:   dec.kind = K_ADD;
        OPC_MUL:   dec.kind = K_MUL;
        OPC_OR:    dec.kind = K_OR;
        OPC_AND:   dec.kind = K_AND;
        OPC_LOAD: begin
          dec.kind = K_LOAD;
          // load target is the A field
          dec.dst  = TRM_DST_W'(dec.src_a);
        end
        OPC_STORE: dec.kind = K_STORE;
        default:   dec.kind = K_NOP;
      endcase
    end
    dec.dst_ok  = {1'b0, dec.dst} < REG_LIMIT;
    dec.addr_ok = {1'b0, dec.addr} < MEM_LIMIT;
  end

  assign in_stall = init_busy || (vld_r && !q_ready);
  assign in_fire  = in_valid && !in_stall;
  assign q_push   = vld_r && q_ready;
  assign q_item   = item_r;

  always_comb begin
    vld_nxt  = in_fire || (vld_r && !q_ready);
    item_nxt = in_fire ? dec : item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ----- rtl/trm_queue.sv -----
// Short request queue between the decode front and the execute back.
module trm_queue
  import trm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  trm_item_t push_item,
  output logic      ready,
  input  logic      pop,
  output logic      head_vld,
  output trm_item_t head_item
);

  localparam int QAW = $clog2(TRM_QUEUE_DEPTH);
  localparam logic [QAW:0] QFULL = (QAW + 1)'(TRM_QUEUE_DEPTH);

  trm_item_t      entries_r [TRM_QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign ready     = cnt_r != QFULL;
  assign head_vld  = cnt_r != '0;
  assign head_item = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW + 1)'(push) - (QAW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !ready)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_vld)) else $error("queue pop while empty");
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

// ----- rtl/trm_back.sv -----
// Execute back end: register file, data memory, forwarding and result register.
module trm_back
  import trm_pkg::*;
#(
  parameter int REG_COUNT  = TRM_REG_COUNT,
  parameter int DATA_WORDS = TRM_DATA_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_vld,
  input  trm_item_t             q_item,
  output logic                  q_pop,
  output logic                  init_busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_reg_written,
  output logic [TRM_DST_W-1:0]  out_reg_index,
  output logic [TRM_WORD_W-1:0] out_reg_value,
  output logic                  out_mem_written,
  output logic [TRM_ADDR_W-1:0] out_mem_address,
  output logic [TRM_WORD_W-1:0] out_mem_value
);

  localparam int RF_AW = $clog2(REG_COUNT);
  localparam int DM_AW = $clog2(DATA_WORDS);
  localparam logic [DM_AW-1:0] DM_LAST = DM_AW'(DATA_WORDS - 1);

  // execute stage
  logic      e2_vld_r, e2_vld_nxt;
  trm_item_t e2_item_r, e2_item_nxt;
  logic      adv, e2_fire;
  trm_item_t sel;

  // register file: two copies give two read ports
  logic [REG_COUNT-1:0]  rf_vld_r, rf_vld_nxt;
  logic                  vld_a_r, vld_b_r;
  logic [RF_AW-1:0]      rf_ra, rf_rb, rf_wa;
  logic [TRM_WORD_W-1:0] rf_rd_a, rf_rd_b;
  logic                  rf_we;
  logic [TRM_WORD_W-1:0] rf_wd;

  // data memory
  logic [DM_AW-1:0]      dm_ra, dm_wa;
  logic [TRM_WORD_W-1:0] dm_rd, dm_wd;
  logic                  dm_we, item_dm_we;

  // clearing pass
  logic             clr_busy_r, clr_busy_nxt;
  logic [DM_AW-1:0] clr_idx_r, clr_idx_nxt;

  // bypass of the write made at the edge that captured the read data
  logic                  fwd_rf_vld_r;
  logic [RF_AW-1:0]      fwd_rf_idx_r;
  logic [TRM_WORD_W-1:0] fwd_rf_val_r;
  logic                  fwd_dm_vld_r;
  logic [DM_AW-1:0]      fwd_dm_adr_r;
  logic [TRM_WORD_W-1:0] fwd_dm_val_r;

  logic [TRM_WORD_W-1:0] op_a, op_b, ld_val, alu_res;

  // result register
  logic                  out_vld_r, out_vld_nxt;
  logic                  o_rw_r, o_mw_r;
  logic [TRM_DST_W-1:0]  o_ri_r;
  logic [TRM_WORD_W-1:0] o_rv_r, o_mv_r;
  logic [TRM_ADDR_W-1:0] o_ma_r;

  assign init_busy = clr_busy_r;
  assign adv       = !e2_vld_r || !out_vld_r || !out_stall;
  assign e2_fire   = e2_vld_r && adv;
  assign q_pop     = adv && q_vld && !clr_busy_r;

  // hold the execute item's addresses while it waits so the read repeats
  assign sel   = adv ? q_item : e2_item_r;
  assign rf_ra = RF_AW'(sel.src_a);
  assign rf_rb = RF_AW'(sel.src_b);
  assign dm_ra = sel.addr[DM_AW-1:0];

  always_comb begin
    e2_vld_nxt  = adv ? q_pop : e2_vld_r;
    e2_item_nxt = q_pop ? q_item : e2_item_r;
  end

  always_comb begin
    op_a = vld_a_r ? rf_rd_a : '0;
    if (fwd_rf_vld_r && fwd_rf_idx_r == RF_AW'(e2_item_r.src_a)) begin
      op_a = fwd_rf_val_r;
    end
    op_b = vld_b_r ? rf_rd_b : '0;
    if (fwd_rf_vld_r && fwd_rf_idx_r == RF_AW'(e2_item_r.src_b)) begin
      op_b = fwd_rf_val_r;
    end
    ld_val = '0;
    if (e2_item_r.addr_ok) begin
      ld_val = (fwd_dm_vld_r && fwd_dm_adr_r == e2_item_r.addr[DM_AW-1:0]) ?
               fwd_dm_val_r : dm_rd;
    end
  end

  always_comb begin
    case (e2_item_r.kind)
      K_ADD:   alu_res = op_a + op_b;
      K_MUL:   alu_res = op_a * op_b;
      K_OR:    alu_res = op_a | op_b;
      K_AND:   alu_res = op_a & op_b;
      K_LOAD:  alu_res = ld_val;
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    rf_we = e2_fire && e2_item_r.dst_ok &&
            (e2_item_r.kind inside {K_ADD, K_MUL, K_OR, K_AND, K_LOAD});
    rf_wa = e2_item_r.dst[RF_AW-1:0];
    rf_wd = alu_res;
    item_dm_we = e2_fire && e2_item_r.addr_ok &&
                 (e2_item_r.kind inside {K_STORE, K_HOST});
    dm_we = clr_busy_r || item_dm_we;
    dm_wa = clr_busy_r ? clr_idx_r : e2_item_r.addr[DM_AW-1:0];
    dm_wd = '0;
    if (!clr_busy_r) begin
      dm_wd = (e2_item_r.kind == K_HOST) ? e2_item_r.value : op_a;
    end
  end

  always_comb begin
    rf_vld_nxt = rf_vld_r;
    if (rf_we) begin
      rf_vld_nxt[rf_wa] = 1'b1;
    end
    clr_busy_nxt = clr_busy_r && (clr_idx_r != DM_LAST);
    clr_idx_nxt  = clr_busy_r ? clr_idx_r + 1'b1 : clr_idx_r;
    out_vld_nxt  = e2_fire || (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      rf_vld_r     <= '0;
      clr_busy_r   <= 1'b1;
      clr_idx_r    <= '0;
      fwd_rf_vld_r <= 1'b0;
      fwd_dm_vld_r <= 1'b0;
    end else begin
      e2_vld_r     <= e2_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      rf_vld_r     <= rf_vld_nxt;
      clr_busy_r   <= clr_busy_nxt;
      clr_idx_r    <= clr_idx_nxt;
      fwd_rf_vld_r <= rf_we;
      fwd_dm_vld_r <= item_dm_we;
    end
    e2_item_r    <= e2_item_nxt;
    vld_a_r      <= rf_vld_r[rf_ra];
    vld_b_r      <= rf_vld_r[rf_rb];
    fwd_rf_idx_r <= rf_wa;
    fwd_rf_val_r <= rf_wd;
    fwd_dm_adr_r <= dm_wa;
    fwd_dm_val_r <= dm_wd;
    if (e2_fire) begin
      o_rw_r <= rf_we;
      o_ri_r <= rf_we ? e2_item_r.dst : '0;
      o_rv_r <= rf_we ? rf_wd : '0;
      o_mw_r <= item_dm_we;
      o_ma_r <= item_dm_we ? e2_item_r.addr : '0;
      o_mv_r <= item_dm_we ? dm_wd : '0;
    end
  end

  trm_ram #(.WIDTH(TRM_WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_wa),
    .wdata (rf_wd),
    .raddr (rf_ra),
    .rdata (rf_rd_a)
  );

  trm_ram #(.WIDTH(TRM_WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_wa),
    .wdata (rf_wd),
    .raddr (rf_rb),
    .rdata (rf_rd_b)
  );

  trm_ram #(.WIDTH(TRM_WORD_W), .DEPTH(DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_wa),
    .wdata (dm_wd),
    .raddr (dm_ra),
    .rdata (dm_rd)
  );

  assign out_valid       = out_vld_r;
  assign out_reg_written = o_rw_r;
  assign out_reg_index   = o_ri_r;
  assign out_reg_value   = o_rv_r;
  assign out_mem_written = o_mw_r;
  assign out_mem_address = o_ma_r;
  assign out_mem_value   = o_mv_r;

`ifndef SYNTH
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!e2_vld_r && !out_vld_r))
    else $error("request in flight during memory clear");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(rf_we && item_dm_we)) else $error("request wrote register and memory");
  a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(o_rw_r && o_mw_r)) else $error("result reports two writes");
  a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |=> fwd_rf_vld_r && fwd_rf_idx_r == $past(rf_wa))
    else $error("register bypass missed a write");
`endif

endmodule

// ----- rtl/tiny_register_machine_execute.sv -----
// Tiny register machine execute block: top level.
//
// Input channel (in_*): one request per accepted item, either a 16-bit
// instruction (in_func = 0) or a host preload of one data word (in_func = 1).
// Result channel (out_*): exactly one result per request, in request order,
// reporting the register write and/or memory write the request made; all
// fields are zero for the write that did not happen.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low.
// Path: decode register, queue, execute stage, result register, in that order.
// Throughput: one request per cycle while in_stall and out_stall stay low, set
// by the single execute stage that reads the register file and data memory and
// writes back in one pass; back-to-back dependences use a one-entry write bypass.
// Reset: the register file reads zero at once (per-entry valid bits); the
// data memory is cleared by a pass over all DATA_WORDS words, during which
// in_stall is high.
// Receiver stall: the result register holds, the execute stage holds, the
// two-entry queue and the decode register fill, then in_stall rises.
module tiny_register_machine_execute
  import trm_pkg::*;
#(
  parameter int REG_COUNT  = TRM_REG_COUNT,
  parameter int DATA_WORDS = TRM_DATA_WORDS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [TRM_INSTR_W-1:0] in_instruction,
  input  logic [TRM_ADDR_W-1:0]  in_host_address,
  input  logic [TRM_WORD_W-1:0]  in_host_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_reg_written,
  output logic [TRM_DST_W-1:0]   out_reg_index,
  output logic [TRM_WORD_W-1:0]  out_reg_value,
  output logic                   out_mem_written,
  output logic [TRM_ADDR_W-1:0]  out_mem_address,
  output logic [TRM_WORD_W-1:0]  out_mem_value
);

  logic      init_busy;
  logic      fq_push, fq_ready;
  trm_item_t fq_item;
  logic      qb_vld, qb_pop;
  trm_item_t qb_item;

  trm_front #(.REG_COUNT(REG_COUNT), .DATA_WORDS(DATA_WORDS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_instruction  (in_instruction),
    .in_host_address (in_host_address),
    .in_host_value   (in_host_value),
    .init_busy       (init_busy),
    .q_ready         (fq_ready),
    .q_push          (fq_push),
    .q_item          (fq_item)
  );

  trm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_item),
    .ready     (fq_ready),
    .pop       (qb_pop),
    .head_vld  (qb_vld),
    .head_item (qb_item)
  );

  trm_back #(.REG_COUNT(REG_COUNT), .DATA_WORDS(DATA_WORDS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_vld           (qb_vld),
    .q_item          (qb_item),
    .q_pop           (qb_pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_written (out_reg_written),
    .out_reg_index   (out_reg_index),
    .out_reg_value   (out_reg_value),
    .out_mem_written (out_mem_written),
    .out_mem_address (out_mem_address),
    .out_mem_value   (out_mem_value)
  );

endmodule
